[rtl/lpe_pkg.sv]
// Shared types, widths and constants of the LED pixel pulse encoder.
`timescale 1ns / 1ps

package lpe_pkg;

	localparam int INDEX_W    = 10;
	localparam int CHAN_W     = 8;
	localparam int PROD_W     = 2 * CHAN_W;
	localparam int TICK_W     = 15;
	localparam int COUNT_W    = 11;
	localparam int WORD_W     = 3 * CHAN_W;
	localparam int SYMBOLS    = 24;
	localparam int SYM_CNT_W  = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam int MAX_LEDS_DEFAULT = 1024;
	localparam int INDEX_SPAN       = 1 << INDEX_W;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [CHAN_W-1:0]  BRIGHTNESS_RST = 8'd255;
	localparam logic [COUNT_W-1:0] CHAIN_LEN_RST  = 11'd1024;
	localparam logic [TICK_W-1:0]  ZERO_HIGH_RST  = 15'd16;
	localparam logic [TICK_W-1:0]  ZERO_LOW_RST   = 15'd34;
	localparam logic [TICK_W-1:0]  ONE_HIGH_RST   = 15'd32;
	localparam logic [TICK_W-1:0]  ONE_LOW_RST    = 15'd18;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BRIGHTNESS = 3'd0,
		CFG_CHAIN_LEN  = 3'd1,
		CFG_ZERO_HIGH  = 3'd2,
		CFG_ZERO_LOW   = 3'd3,
		CFG_ONE_HIGH   = 3'd4,
		CFG_ONE_LOW    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  brightness;
		logic [COUNT_W-1:0] chain_len;
		logic [TICK_W-1:0]  zero_high_ticks;
		logic [TICK_W-1:0]  zero_low_ticks;
		logic [TICK_W-1:0]  one_high_ticks;
		logic [TICK_W-1:0]  one_low_ticks;
	} cfg_t;

	// Handshake between the control sequencer and the symbol encoder.
	typedef struct packed {
		logic load;
	} enc_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} enc_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_LOAD,
		ST_EMIT
	} state_t;

endpackage

[rtl/lpe_if.sv]
// Stream interfaces for pixel items in and pulse symbols out.
`timescale 1ns / 1ps

interface lpe_in_if;
	import lpe_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [INDEX_W-1:0] index;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, kind, index, red, green, blue, input ready);
	modport sink (input valid, kind, index, red, green, blue, output ready);
endinterface

interface lpe_out_if;
	import lpe_pkg::*;

	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] high_ticks;
	logic [TICK_W-1:0] low_ticks;
	logic              last;

	modport source (output valid, high_ticks, low_ticks, last, input ready);
	modport sink (input valid, high_ticks, low_ticks, last, output ready);
endinterface

[rtl/lpe_cfg_regs.sv]
// Configuration register bank written through a plain write port.
`timescale 1ns / 1ps

module lpe_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [lpe_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [lpe_pkg::CFG_DATA_W-1:0] wr_data,
	output lpe_pkg::cfg_t                 cfg
);
	import lpe_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness      <= BRIGHTNESS_RST;
			cfg_q.chain_len       <= CHAIN_LEN_RST;
			cfg_q.zero_high_ticks <= ZERO_HIGH_RST;
			cfg_q.zero_low_ticks  <= ZERO_LOW_RST;
			cfg_q.one_high_ticks  <= ONE_HIGH_RST;
			cfg_q.one_low_ticks   <= ONE_LOW_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				CFG_BRIGHTNESS: cfg_q.brightness      <= wr_data[CHAN_W-1:0];
				CFG_CHAIN_LEN:  cfg_q.chain_len       <= wr_data[COUNT_W-1:0];
				CFG_ZERO_HIGH:  cfg_q.zero_high_ticks <= wr_data[TICK_W-1:0];
				CFG_ZERO_LOW:   cfg_q.zero_low_ticks  <= wr_data[TICK_W-1:0];
				CFG_ONE_HIGH:   cfg_q.one_high_ticks  <= wr_data[TICK_W-1:0];
				CFG_ONE_LOW:    cfg_q.one_low_ticks   <= wr_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[rtl/lpe_scaler.sv]
// Brightness scaling of one pixel: registered products, then divide by 255.
`timescale 1ns / 1ps

module lpe_scaler (
	input  logic                       clk,
	input  logic                       capture,
	input  logic [lpe_pkg::CHAN_W-1:0] red,
	input  logic [lpe_pkg::CHAN_W-1:0] green,
	input  logic [lpe_pkg::CHAN_W-1:0] blue,
	input  logic [lpe_pkg::CHAN_W-1:0] brightness,
	output logic [lpe_pkg::WORD_W-1:0] word
);
	import lpe_pkg::*;

	logic [PROD_W-1:0] prod_r_s1;
	logic [PROD_W-1:0] prod_g_s1;
	logic [PROD_W-1:0] prod_b_s1;

	// Quotient by 255 of a product of two bytes. The estimate (p + p/256) / 256
	// is never above the true quotient and at most one below it, so a single
	// remainder check finishes the job.
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
		logic [PROD_W:0]   sum;
		logic [CHAN_W:0]   est;
		logic [PROD_W:0]   est_x255;
		logic [PROD_W:0]   rem;
		logic [CHAN_W:0]   quo;
		sum      = {1'b0, p} + {{(PROD_W-CHAN_W+1){1'b0}}, p[PROD_W-1:CHAN_W]};
		est      = sum[PROD_W:CHAN_W];
		est_x255 = {est, {CHAN_W{1'b0}}} - {{(PROD_W-CHAN_W){1'b0}}, est};
		rem      = {1'b0, p} - est_x255;
		quo      = (rem >= (PROD_W+1)'(255)) ? est + (CHAN_W+1)'(1) : est;
		return quo[CHAN_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (capture) begin
			prod_r_s1 <= {{CHAN_W{1'b0}}, red}   * {{CHAN_W{1'b0}}, brightness};
			prod_g_s1 <= {{CHAN_W{1'b0}}, green} * {{CHAN_W{1'b0}}, brightness};
			prod_b_s1 <= {{CHAN_W{1'b0}}, blue}  * {{CHAN_W{1'b0}}, brightness};
		end
	end

	// Stored word layout: green, red, blue from the top byte down.
	assign word = {div255(prod_g_s1), div255(prod_r_s1), div255(prod_b_s1)};
endmodule

[rtl/lpe_store.sv]
// Pixel memory with registered read and a clearing pass after reset.
`timescale 1ns / 1ps

module lpe_store #(
	parameter int DEPTH  = lpe_pkg::MAX_LEDS_DEFAULT,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [lpe_pkg::WORD_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [lpe_pkg::WORD_W-1:0] rd_data,
	output logic                       clearing
);
	import lpe_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clearing_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = wr_en;
			mem_waddr = wr_addr;
			mem_wdata = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;
endmodule

[rtl/lpe_encoder.sv]
// Turns a stored pixel word into 24 pulse symbols, most significant bit first.
`timescale 1ns / 1ps

module lpe_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lpe_pkg::enc_ctrl_t         ctrl,
	input  logic [lpe_pkg::WORD_W-1:0] word,
	input  lpe_pkg::cfg_t              cfg,
	lpe_out_if.source                  sym_out,
	output lpe_pkg::enc_status_t       status
);
	import lpe_pkg::*;

	logic [WORD_W-1:0]    word_q;
	logic [SYM_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 is_last;
	logic                 sym_accept;

	assign is_last    = (cnt_q == SYM_CNT_W'(SYMBOLS - 1));
	assign sym_accept = busy_q && sym_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (sym_accept) begin
			cnt_q <= cnt_q + SYM_CNT_W'(1);
			if (is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= word;
		end else if (sym_accept) begin
			word_q <= {word_q[WORD_W-2:0], 1'b0};
		end
	end

	// Durations use live cfg; the user, not the block, keeps it while busy.
	assign sym_out.valid      = busy_q;
	assign sym_out.high_ticks = word_q[WORD_W-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
	assign sym_out.low_ticks  = word_q[WORD_W-1] ? cfg.one_low_ticks : cfg.zero_low_ticks;
	assign sym_out.last       = is_last;

	assign status.busy = busy_q;
	assign status.done = sym_accept && is_last;
endmodule

[rtl/led_pixel_pulse_encoder.sv]
// Top level of the LED pixel pulse encoder: pixel store, scaler and symbol encoder.
//
//   Channel   Dir  Handshake          Payload
//   pix_in    in   valid / ready      kind, index, red, green, blue
//   sym_out   out  valid / ready      high_ticks, low_ticks, last
//   cfg_wr    in   cfg_wr_en only     cfg_wr_index, cfg_wr_data
//
// A write item registers the brightness products, then the division by 255 feeds
// the memory write port. A read item fetches the word through the registered memory
// read, loads it into the encoder, then sends one symbol per cycle while the sink
// does not stall; an out-of-range item is taken and dropped.
// After reset the memory is cleared one entry a cycle (min(MAX_LEDS, 1024)
// entries, 1024 by default) and no item is taken before that pass ends.
// A stalled sink holds the current symbol; no new item is taken until the last
// symbol of the current pixel has been accepted.
`timescale 1ns / 1ps

module led_pixel_pulse_encoder #(
	parameter int MAX_LEDS = lpe_pkg::MAX_LEDS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lpe_in_if.sink                        pix_in,
	lpe_out_if.source                     sym_out,
	input  logic                          cfg_wr_en,
	input  logic [lpe_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
	input  logic [lpe_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
	import lpe_pkg::*;

	// Only indices the 10-bit field can reach need storage.
	localparam int DEPTH  = (MAX_LEDS < INDEX_SPAN) ? MAX_LEDS : INDEX_SPAN;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [16:0] IDX_LIMIT = 17'(MAX_LEDS);

	cfg_t              cfg;
	state_t            state_q;
	state_t            state_d;
	logic [ADDR_W-1:0] idx_q;
	logic              clearing;
	logic              accept;
	logic              in_range;
	logic              wr_accept;
	logic              rd_accept;
	logic [WORD_W-1:0] scaled_word;
	logic [WORD_W-1:0] rd_word;
	enc_ctrl_t         enc_ctrl;
	enc_status_t       enc_status;

	lpe_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_wr_index),
		.wr_data  (cfg_wr_data),
		.cfg      (cfg)
	);

	// The block takes an item only when it is idle and the memory is cleared.
	assign pix_in.ready = (state_q == ST_IDLE) && !clearing;
	assign accept       = pix_in.valid && pix_in.ready;

	// An index at or above the LED count or the store depth is dropped.
	assign in_range  = ({1'b0, pix_in.index} < cfg.chain_len) &&
	                   ({7'b0, pix_in.index} < IDX_LIMIT);
	assign wr_accept = accept && in_range && (pix_in.kind == KIND_WRITE);
	assign rd_accept = accept && in_range && (pix_in.kind == KIND_READ);

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= pix_in.index[ADDR_W-1:0];
		end
	end

	lpe_scaler u_scaler (
		.clk        (clk),
		.capture    (wr_accept),
		.red        (pix_in.red),
		.green      (pix_in.green),
		.blue       (pix_in.blue),
		.brightness (cfg.brightness),
		.word       (scaled_word)
	);

	// The read address comes straight from the item so the word is ready
	// in the cycle after the item is taken.
	lpe_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (state_q == ST_WRITE),
		.wr_addr  (idx_q),
		.wr_data  (scaled_word),
		.rd_en    (rd_accept),
		.rd_addr  (pix_in.index[ADDR_W-1:0]),
		.rd_data  (rd_word),
		.clearing (clearing)
	);

	assign enc_ctrl.load = (state_q == ST_LOAD);

	lpe_encoder u_encoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (enc_ctrl),
		.word    (rd_word),
		.cfg     (cfg),
		.sym_out (sym_out),
		.status  (enc_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: a write passes through the write state, a read through the load state,
	// where it loads the encoder, and then waits for its last symbol to be taken.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (wr_accept) begin
					state_d = ST_WRITE;
				end else if (rd_accept) begin
					state_d = ST_LOAD;
				end
			end
			ST_WRITE: begin
				state_d = ST_IDLE;
			end
			ST_LOAD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (enc_status.done || !enc_status.busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
